// ===== design/rsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Register script byte parser package
// Shared opcodes, item and command types for the script byte parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rsbp_pkg;

    localparam int unsigned ByteW = 8;

    // Script opcodes. Any other byte in the opcode position is a register address.
    localparam logic [ByteW-1:0] OP_DELAY = 8'hfe;
    localparam logic [ByteW-1:0] OP_BURST = 8'hfd;
    localparam logic [ByteW-1:0] OP_TEXT  = 8'hf0;

    // Command kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DELAY = 1'b1;

    typedef struct packed {
        logic [ByteW-1:0] script_byte;
        logic             last_byte;
    } t_item;

    typedef struct packed {
        logic             cmd_kind;
        logic [ByteW-1:0] reg_addr;
        logic [ByteW-1:0] cmd_value;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/rsbp_ifs.sv =====
// ----------------------------------------------------------------------------
// Register script byte parser channels
// Valid/ready channels for script bytes in and commands out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] script_byte;
    logic       last_byte;

    modport source (output valid, output script_byte, output last_byte, input ready);
    modport sink   (input valid, input script_byte, input last_byte, output ready);
endinterface

interface rsbp_out_if;
    logic       valid;
    logic       ready;
    logic       cmd_kind;
    logic [7:0] reg_addr;
    logic [7:0] cmd_value;

    modport source (output valid, output cmd_kind, output reg_addr, output cmd_value,
                    input ready);
    modport sink   (input valid, input cmd_kind, input reg_addr, input cmd_value,
                    output ready);
endinterface

`default_nettype wire

// ===== design/rsbp_parse.sv =====
// ----------------------------------------------------------------------------
// Register script byte parser state machine
// Holds the parse phase and counters; decodes one registered byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbp_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire rsbp_pkg::t_item i_item,
    output logic               o_emit,
    output rsbp_pkg::t_cmd     o_cmd
);
    import rsbp_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_VALUE,
        PH_DELAY,
        PH_BURST_LEN,
        PH_BURST_ADDR,
        PH_BURST_DATA,
        PH_TEXT_LEN,
        PH_TEXT_SKIP
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [ByteW-1:0] r_left, n_left;
    logic [ByteW-1:0] r_addr, n_addr;
    logic [ByteW-1:0] w_byte;

    assign w_byte = i_item.script_byte;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_addr  = r_addr;
        o_emit  = 1'b0;
        o_cmd   = '{cmd_kind: KIND_WRITE, reg_addr: r_addr, cmd_value: w_byte};

        case (r_phase)
            PH_VALUE: begin
                o_emit  = 1'b1;
                n_phase = PH_OPCODE;
            end
            PH_DELAY: begin
                o_emit         = 1'b1;
                o_cmd.cmd_kind = KIND_DELAY;
                o_cmd.reg_addr = '0;
                n_phase        = PH_OPCODE;
            end
            PH_BURST_ADDR: begin
                n_addr  = w_byte;
                n_phase = (r_left == '0) ? PH_OPCODE : PH_BURST_DATA;
            end
            PH_BURST_DATA: begin
                o_emit = 1'b1;
                n_addr = r_addr + 8'd1;
                n_left = (r_left != '0) ? r_left - 8'd1 : r_left;
                if (n_left == '0) begin
                    n_phase = PH_OPCODE;
                end
            end
            PH_TEXT_SKIP: begin
                n_left = (r_left != '0) ? r_left - 8'd1 : r_left;
                if (n_left == '0) begin
                    n_phase = PH_OPCODE;
                end
            end
            default: begin
                // Opcode position, or a length byte. A zero length byte is
                // reread as an opcode, which makes it register address zero.
                if ((r_phase inside {PH_BURST_LEN, PH_TEXT_LEN}) && w_byte == 8'd1) begin
                    n_phase = PH_OPCODE;
                end else if (r_phase == PH_BURST_LEN && w_byte != '0) begin
                    n_left  = w_byte - 8'd2;
                    n_phase = PH_BURST_ADDR;
                end else if (r_phase == PH_TEXT_LEN && w_byte != '0) begin
                    n_left  = w_byte - 8'd1;
                    n_phase = PH_TEXT_SKIP;
                end else if (w_byte == OP_DELAY) begin
                    n_phase = PH_DELAY;
                end else if (w_byte == OP_BURST) begin
                    n_phase = PH_BURST_LEN;
                end else if (w_byte == OP_TEXT) begin
                    n_phase = PH_TEXT_LEN;
                end else begin
                    n_addr  = w_byte;
                    n_phase = PH_VALUE;
                end
            end
        endcase

        // The final byte of a script drops any unfinished command.
        if (i_item.last_byte) begin
            n_phase = PH_OPCODE;
            n_left  = '0;
            n_addr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_left  <= '0;
            r_addr  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_addr  <= n_addr;
        end
    end

endmodule

`default_nettype wire

// ===== design/register_script_byte_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Register script byte parser unit
// Turns a codec configuration script, one byte per item, into commands.
// ----------------------------------------------------------------------------
// Script bytes arrive on i_item, one item per cycle while i_item.ready is
// high, and come out, where they complete a command, as register writes or
// millisecond delay requests on o_cmd. The unit sustains one script byte
// per clock cycle unless the command register is full and stalled. A command
// passes the input register and then the command register. The rate is set
// by the parser state machine, whose phase, remaining count and pending
// address are updated once for every byte. Because the command register
// frees itself in the same cycle its item is taken, a full output does not
// stop the input as long as the sink keeps taking commands. A byte marked as
// the last of a script is decoded as usual and then the parser returns to the
// opcode phase, so a command cut off by the end of a script produces nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module register_script_byte_parser_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsbp_in_if.sink    i_item,
    rsbp_out_if.source o_cmd
);
    import rsbp_pkg::*;

    // Input register stage.
    logic  r_s1_valid;
    t_item r_s1_item;

    // Command register stage.
    logic  r_out_valid;
    t_cmd  r_out_cmd;

    logic  w_emit;
    t_cmd  w_cmd;
    logic  w_out_free;
    logic  w_s1_go;

    // The command register can be loaded when it is empty or being drained.
    assign w_out_free = !r_out_valid || o_cmd.ready;

    // The registered byte moves on unless it completes a command and the
    // command register cannot take it this cycle.
    assign w_s1_go = r_s1_valid && (!w_emit || w_out_free);

    assign i_item.ready = !r_s1_valid || w_s1_go;

    rsbp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_s1_go),
        .i_item  (r_s1_item),
        .o_emit  (w_emit),
        .o_cmd   (w_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_s1_item.script_byte <= i_item.script_byte;
            r_s1_item.last_byte   <= i_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && w_emit) begin
            r_out_cmd <= w_cmd;
        end
    end

    assign o_cmd.valid     = r_out_valid;
    assign o_cmd.cmd_kind  = r_out_cmd.cmd_kind;
    assign o_cmd.reg_addr  = r_out_cmd.reg_addr;
    assign o_cmd.cmd_value = r_out_cmd.cmd_value;

endmodule

`default_nettype wire

// ===== design/rsbp_checker.sv =====
// ----------------------------------------------------------------------------
// Register script byte parser checker
// Port-level assertions on the parser unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_out_kind,
    input wire logic [7:0] i_out_addr,
    input wire logic [7:0] i_out_value
);
    import rsbp_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    // No command is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("command valid after reset");

    // A stalled command holds its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_addr)
            && $stable(i_out_value))
        else $error("stalled command changed");

    // A delay request never carries a register address.
    a_delay_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_DELAY |-> i_out_addr == '0)
        else $error("delay with nonzero address");

    // A command that appears on an idle output comes from a byte that was taken
    // into the input register and then straight into the command register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc, 2))
        else $error("command without a recent byte");

endmodule

bind register_script_byte_parser_unit rsbp_checker u_rsbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_out_kind  (o_cmd.cmd_kind),
    .i_out_addr  (o_cmd.reg_addr),
    .i_out_value (o_cmd.cmd_value)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register script byte parser testbench
// Feeds configuration scripts into the parser, one byte per item, and checks
// every command that comes out against an in-bench decoder of the script.
// ----------------------------------------------------------------------------
// A queue of script bytes is filled by the stimulus process and drained by a
// clocked driver. Each byte that the unit accepts is run through the decoder
// below, which keeps its own parse phase, remaining count and write address
// and queues the command the byte completes, if any. A clocked monitor takes
// commands from the unit and compares each one, field by field, with the
// oldest queued command. The run passes through phases with different idle
// and stall rates, one long hold-off of the command sink while the driver
// keeps offering bytes, and pauses in which the stimulus waits until every
// expected command has arrived.
// ----------------------------------------------------------------------------

module tb;
    import rsbp_pkg::*;

    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned PHASE_ITEMS    = 100;

    // Phases of the script decoder, in the order the unit numbers them.
    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_VALUE,
        PH_DELAY,
        PH_BURST_LEN,
        PH_BURST_ADDR,
        PH_BURST_DATA,
        PH_TEXT_LEN,
        PH_TEXT_SKIP
    } t_phase;

    logic i_clk;
    logic i_rst_n;

    rsbp_in_if  script_if ();
    rsbp_out_if cmd_if ();

    register_script_byte_parser_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (script_if.sink),
        .o_cmd   (cmd_if.source)
    );

    // Bytes waiting to be offered, and commands the accepted bytes call for.
    t_item script_pending[$];
    t_cmd  cmd_expected[$];

    // Decoder state; it starts as the unit does after reset.
    t_phase     dec_phase  = PH_OPCODE;
    logic [7:0] bytes_due  = 8'h00;
    logic [7:0] write_addr = 8'h00;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_queued   = 0;
    int unsigned error_count    = 0;
    int unsigned idle_cycles    = 0;
    int unsigned hold_left      = 0;
    logic        hold_start     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // A byte in the opcode position selects a command or, if it is not one
    // of the three opcodes, is the register address of a plain write.
    function automatic void enter_opcode(input logic [7:0] b);
        if (b == OP_DELAY) begin
            dec_phase = PH_DELAY;
        end else if (b == OP_BURST) begin
            dec_phase = PH_BURST_LEN;
        end else if (b == OP_TEXT) begin
            dec_phase = PH_TEXT_LEN;
        end else begin
            write_addr = b;
            dec_phase  = PH_VALUE;
        end
    endfunction

    // Advances the decoder by one accepted byte and queues the command that
    // the byte completes.
    function automatic void decode_script_byte(input t_item it);
        logic [7:0] b;
        t_cmd       c;
        logic       emit;
        b    = it.script_byte;
        c    = '0;
        emit = 1'b0;
        case (dec_phase)
            PH_OPCODE: begin
                enter_opcode(b);
            end
            PH_VALUE: begin
                c         = '{KIND_WRITE, write_addr, b};
                emit      = 1'b1;
                dec_phase = PH_OPCODE;
            end
            PH_DELAY: begin
                c         = '{KIND_DELAY, 8'h00, b};
                emit      = 1'b1;
                dec_phase = PH_OPCODE;
            end
            PH_BURST_LEN: begin
                // The length counts itself; zero is read as an opcode.
                if (b == 8'd0) begin
                    enter_opcode(b);
                end else if (b == 8'd1) begin
                    dec_phase = PH_OPCODE;
                end else begin
                    bytes_due = b - 8'd2;
                    dec_phase = PH_BURST_ADDR;
                end
            end
            PH_BURST_ADDR: begin
                write_addr = b;
                dec_phase  = (bytes_due == 8'd0) ? PH_OPCODE : PH_BURST_DATA;
            end
            PH_BURST_DATA: begin
                c          = '{KIND_WRITE, write_addr, b};
                emit       = 1'b1;
                write_addr = write_addr + 8'd1;
                if (bytes_due != 8'd0) begin
                    bytes_due = bytes_due - 8'd1;
                end
                if (bytes_due == 8'd0) begin
                    dec_phase = PH_OPCODE;
                end
            end
            PH_TEXT_LEN: begin
                if (b == 8'd0) begin
                    enter_opcode(b);
                end else if (b == 8'd1) begin
                    dec_phase = PH_OPCODE;
                end else begin
                    bytes_due = b - 8'd1;
                    dec_phase = PH_TEXT_SKIP;
                end
            end
            default: begin
                if (bytes_due != 8'd0) begin
                    bytes_due = bytes_due - 8'd1;
                end
                if (bytes_due == 8'd0) begin
                    dec_phase = PH_OPCODE;
                end
            end
        endcase
        // The last byte of a script drops whatever command is still open.
        if (it.last_byte) begin
            dec_phase  = PH_OPCODE;
            bytes_due  = 8'h00;
            write_addr = 8'h00;
        end
        if (emit) begin
            cmd_expected.push_back(c);
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        script_pending.push_back('{script_byte: b, last_byte: last});
        items_queued++;
    endtask

    // Random bytes, each marked as the end of a script now and then, so that
    // some commands are cut off part way.
    task automatic push_random_byte(input logic [7:0] b);
        push_byte(b, $urandom_range(39) == 0);
    endtask

    // Appends one randomly chosen script command with random content; a
    // small share of plain noise bytes is mixed in.
    task automatic push_random_command();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 40) begin
            do begin
                b = 8'($urandom);
            end while (b == OP_DELAY || b == OP_BURST || b == OP_TEXT);
            push_random_byte(b);
            push_random_byte(8'($urandom));
        end else if (pick < 55) begin
            push_random_byte(OP_DELAY);
            push_random_byte(8'($urandom));
        end else if (pick < 80) begin
            // Mostly short bursts; now and then one of any length.
            len = ($urandom_range(11) == 0) ? $urandom_range(255) : $urandom_range(8);
            push_random_byte(OP_BURST);
            push_random_byte(8'(len));
            if (len == 0) begin
                push_random_byte(8'($urandom));
            end
            if (len >= 2) begin
                push_random_byte(8'($urandom));
                repeat (len - 2) push_random_byte(8'($urandom));
            end
        end else if (pick < 90) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(6);
            push_random_byte(OP_TEXT);
            push_random_byte(8'(len));
            if (len == 0) begin
                push_random_byte(8'($urandom));
            end
            if (len >= 2) begin
                repeat (len - 1) push_random_byte(8'($urandom));
            end
        end else begin
            push_random_byte(8'($urandom));
        end
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = items_queued + n_items;
        while (items_queued < stop_at) begin
            push_random_command();
        end
    endtask

    // Waits on the falling edge until every byte has been taken and every
    // expected command has come back.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (script_pending.size() != 0 || script_if.valid || cmd_expected.size() != 0);
    endtask

    // Driver: offers the next pending byte, with random gaps, and runs every
    // accepted byte through the decoder.
    always @(posedge i_clk) begin : drive_script
        t_item nxt;
        if (!i_rst_n) begin
            script_if.valid <= 1'b0;
        end else begin
            if (script_if.valid && script_if.ready) begin
                decode_script_byte('{script_byte: script_if.script_byte,
                                     last_byte:   script_if.last_byte});
            end
            if (!script_if.valid || script_if.ready) begin
                if (script_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = script_pending.pop_front();
                    script_if.valid       <= 1'b1;
                    script_if.script_byte <= nxt.script_byte;
                    script_if.last_byte   <= nxt.last_byte;
                end else begin
                    script_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes commands, with random stalls and the long hold-off, and
    // checks each against the oldest expected command.
    always @(posedge i_clk) begin : check_commands
        t_cmd want;
        if (!i_rst_n) begin
            cmd_if.ready <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                if (cmd_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected command kind %0d addr %02h value %02h",
                                              cmd_if.cmd_kind, cmd_if.reg_addr,
                                              cmd_if.cmd_value));
                end else begin
                    want = cmd_expected.pop_front();
                    if (cmd_if.cmd_kind !== want.cmd_kind) begin
                        report_mismatch($sformatf("cmd_kind %0d, expected %0d",
                                                  cmd_if.cmd_kind, want.cmd_kind));
                    end
                    if (cmd_if.reg_addr !== want.reg_addr) begin
                        report_mismatch($sformatf("reg_addr %02h, expected %02h",
                                                  cmd_if.reg_addr, want.reg_addr));
                    end
                    if (cmd_if.cmd_value !== want.cmd_value) begin
                        report_mismatch($sformatf("cmd_value %02h, expected %02h",
                                                  cmd_if.cmd_value, want.cmd_value));
                    end
                end
            end
            cmd_if.ready <= !hold_start && hold_left == 0 &&
                            $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Long hold-off of the command sink, counted here in clock cycles.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog: too long without any item or command taken means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (script_if.valid && script_if.ready) ||
            (cmd_if.valid && cmd_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        script_if.valid       = 1'b0;
        script_if.script_byte = 8'h00;
        script_if.last_byte   = 1'b0;
        cmd_if.ready          = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed script, no idling.
        // Plain writes at both ends of the address and value range.
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        // Longest delay.
        push_byte(OP_DELAY, 1'b0);
        push_byte(8'hff, 1'b0);
        // Burst from 0xfe with three data bytes, so the address wraps past 0xff.
        push_byte(OP_BURST, 1'b0);
        push_byte(8'd5, 1'b0);
        push_byte(8'hfe, 1'b0);
        push_byte(8'ha5, 1'b0);
        push_byte(8'h5a, 1'b0);
        push_byte(8'hf0, 1'b0);
        // A zero burst length is itself the address of a plain write.
        push_byte(OP_BURST, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'h3c, 1'b0);
        // Burst of length one carries nothing; a zero delay follows.
        push_byte(OP_BURST, 1'b0);
        push_byte(8'd1, 1'b0);
        push_byte(OP_DELAY, 1'b0);
        push_byte(8'h00, 1'b0);
        // Burst of length two has a start register and no data.
        push_byte(OP_BURST, 1'b0);
        push_byte(8'd2, 1'b0);
        push_byte(8'h80, 1'b0);
        // Text of length zero, one and two; the skipped byte looks like an opcode.
        push_byte(OP_TEXT, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'h7e, 1'b0);
        push_byte(OP_TEXT, 1'b0);
        push_byte(8'd1, 1'b0);
        push_byte(OP_TEXT, 1'b0);
        push_byte(8'd2, 1'b0);
        push_byte(OP_BURST, 1'b0);
        // A last byte that completes a write, then one that cuts a burst short.
        push_byte(8'h21, 1'b0);
        push_byte(8'h99, 1'b1);
        push_byte(OP_BURST, 1'b0);
        push_byte(8'd6, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(8'h01, 1'b1);
        wait_drained();

        // Random scripts without idling.
        run_random_phase(PHASE_ITEMS);
        wait_drained();

        // The sink holds off for a long stretch while the driver keeps
        // offering bytes, so the unit fills up and stalls its input.
        run_random_phase(60);
        hold_start = 1'b1;
        @(negedge i_clk);
        hold_start = 1'b0;
        wait_drained();

        // Driver idle most of the time.
        send_idle_pct = 78;
        run_random_phase(PHASE_ITEMS);
        wait_drained();

        // Sink stalling most of the time.
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        run_random_phase(PHASE_ITEMS);
        wait_drained();

        // Light idling on both sides.
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random_phase(PHASE_ITEMS);
        wait_drained();

        // Any stray command would show up during this final wait.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
